@@ design/pixel_gamma_contrast_brightness_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gamma / contrast / brightness block
// Implication checks clocked on clk and muted while rst is high.
// ----------------------------------------------------------------------------
`ifndef PIXEL_GAMMA_CONTRAST_BRIGHTNESS_ASSERT_SVH
`define PIXEL_GAMMA_CONTRAST_BRIGHTNESS_ASSERT_SVH

// same-cycle implication
`define PGCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pgcb_pkg.sv @@
// ----------------------------------------------------------------------------
// pgcb_pkg
// Shared types, constants and elaboration-time tables for the gamma block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgcb_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CHANNELS  = 3;
  localparam int LOG_FRAC  = 24;
  localparam int NST       = 31;   // pipeline stages, output register included

  // register indexes
  localparam logic [1:0] IDX_GAIN     = 2'd0;
  localparam logic [1:0] IDX_BIAS     = 2'd1;
  localparam logic [1:0] IDX_EXPONENT = 2'd2;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
  } pix_out_t;

  typedef logic [255:0][27:0]      dtab_t;
  typedef logic [LOG_FRAC:1][32:0] rtab_t;

  // integer log2, LOG_FRAC fraction bits, by repeated squaring
  function automatic logic [31:0] log2_fix(input int unsigned v);
    int unsigned       k;
    longint unsigned   m;
    logic [LOG_FRAC-1:0] frac;
    k = 7;
    frac = '0;
    while (k > 0 && ((v >> k) & 1) == 0) k = k - 1;
    m = longint'(v) << (31 - k);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = {frac[LOG_FRAC-2:0], 1'b0};
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {k[7:0], frac};
  endfunction

  // distance log2(255) - log2(v) for every nonzero byte; entry 0 is zero
  function automatic dtab_t build_dtab();
    dtab_t       tab;
    logic [31:0] l255;
    logic [31:0] lv;
    l255 = log2_fix(255);
    tab = '0;
    for (int v = 1; v < 256; v++) begin
      lv = log2_fix(v);
      tab[v] = 28'(l255 - lv);
    end
    return tab;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned a);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bt;
    rem = a;
    res = 0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-i) in Q.32 by iterated square roots of 1/2
  function automatic rtab_t build_rtab();
    rtab_t           tab;
    longint unsigned r;
    r = 64'd1 << 31;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      r = isqrt64(r << 32);
      tab[i] = 33'(r);
    end
    return tab;
  endfunction

  localparam dtab_t DTAB = build_dtab();
  localparam rtab_t RTAB = build_rtab();

endpackage

`default_nettype wire

@@ design/pgcb_chan.sv @@
// ----------------------------------------------------------------------------
// pgcb_chan
// Datapath of one channel: log lookup, exponent scale, exp2 product chain,
// integer shift, gain, bias, x255, rounding and saturation, one register stage each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgcb_chan
  import pgcb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [NST-1:0]      ld,
  input  wire logic [7:0]          v,
  input  wire logic [15:0]         gain,
  input  wire logic signed [15:0]  bias,
  input  wire logic [15:0]         exponent,
  output logic [7:0]               q
);

  // stage 1: log distance lookup
  logic [27:0] d1;
  logic        z1;
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d1 <= DTAB[v];
      z1 <= (v == 8'd0);
    end
  end

  // stage 2: scale by exponent
  logic [43:0] dprod;
  logic [29:0] t2;
  logic        z2;
  assign dprod = 44'(d1) * 44'(exponent);
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      t2 <= dprod[43:FRAC_BITS];
      z2 <= z1;
    end
  end

  // stages 3..26: one conditional root product per fraction bit
  logic [LOG_FRAC:0][32:0]         ys;
  logic [LOG_FRAC:0][LOG_FRAC-1:0] fs;
  logic [LOG_FRAC:0][5:0]          ns;
  logic [LOG_FRAC:0]               zs;

  assign ys[0] = 33'd1 << 32;
  assign fs[0] = t2[LOG_FRAC-1:0];
  assign ns[0] = t2[29:LOG_FRAC];
  assign zs[0] = z2;

  for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_exp
    logic [65:0] pr;
    assign pr = 66'(ys[j-1]) * 66'(RTAB[j]);
    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        ys[j] <= fs[j-1][LOG_FRAC-j] ? pr[64:32] : ys[j-1];
        fs[j] <= fs[j-1];
        ns[j] <= ns[j-1];
        zs[j] <= zs[j-1];
      end
    end
  end

  // stage 27: integer part shift and zero channel case
  logic [32:0] yv;
  always_ff @(posedge clk) begin
    if (ld[LOG_FRAC+2]) begin
      if (zs[LOG_FRAC]) begin
        yv <= (exponent == 16'd0) ? (33'd1 << 32) : 33'd0;
      end else begin
        yv <= ys[LOG_FRAC] >> ns[LOG_FRAC];
      end
    end
  end

  // stage 28: gain
  logic [48:0] p;
  always_ff @(posedge clk) begin
    if (ld[LOG_FRAC+3]) begin
      p <= 49'(yv) * 49'(gain);
    end
  end

  // stage 29: bias
  logic signed [49:0] acc;
  always_ff @(posedge clk) begin
    if (ld[LOG_FRAC+4]) begin
      acc <= $signed({1'b0, p}) + $signed({{2{bias[15]}}, bias, 32'b0});
    end
  end

  // stage 30: times 255
  logic signed [57:0] a255;
  always_ff @(posedge clk) begin
    if (ld[LOG_FRAC+5]) begin
      a255 <= $signed({acc, 8'b0}) - 58'(acc);
    end
  end

  // stage 31: round half up, clamp
  logic [57:0] rnd;
  logic [11:0] qw;
  assign rnd = a255 + (58'd1 << (FRAC_BITS + 31));
  assign qw  = rnd[57:FRAC_BITS+32];
  always_ff @(posedge clk) begin
    if (ld[LOG_FRAC+6]) begin
      if (a255[57] || a255 == '0) begin
        q <= 8'd0;
      end else if (qw > 12'd255) begin
        q <= 8'd255;
      end else begin
        q <= qw[7:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/pixel_gamma_contrast_brightness.sv @@
// ----------------------------------------------------------------------------
// pixel_gamma_contrast_brightness
// Per-channel gamma, contrast and brightness correction of 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one three-channel pixel per transfer;
//   out_valid/out_ready/out_data carry the corrected pixel, one per input.
//   cfg_we/cfg_index/cfg_data write gain (0), bias (1), exponent (2);
//   write only while the pipeline holds no pixel.
// Pipeline: log, scale, the 24-step exp2 multiply chain, integer shift,
//   gain, bias, x255 and round stages.
// Throughput: one pixel per cycle while out_ready keeps the pipeline moving.
// Stall: each stage advances whenever it is empty or its successor moves, so
//   bubbles close up and input keeps flowing while a result waits; a full
//   pipeline holds every stage until out_ready returns.
// Reset: clears all stage valid bits and loads gain 1.0, bias 0, gamma 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_gamma_contrast_brightness
  import pgcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire pix_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output pix_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0]        gain;
  logic signed [15:0] bias;
  logic [15:0]        exponent;
  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= 16'd16384;
      bias     <= 16'sd0;
      exponent <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        IDX_GAIN:     gain     <= cfg_data;
        IDX_BIAS:     bias     <= $signed(cfg_data);
        IDX_EXPONENT: exponent <= cfg_data;
        default:      ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NST:0]   vld;
  logic [NST+1:1] adv;
  assign vld[0]       = in_valid;
  assign adv[NST+1]   = out_ready;
  for (genvar k = 1; k <= NST; k++) begin : g_ctl
    assign adv[k] = !vld[k] || adv[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[NST];

  // channel datapaths
  logic [CHANNELS-1:0][7:0] vin;
  logic [CHANNELS-1:0][7:0] vout;
  assign vin[0] = in_data.chan_a;
  assign vin[1] = in_data.chan_b;
  assign vin[2] = in_data.chan_c;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    pgcb_chan u_chan (
      .clk      (clk),
      .ld       (adv[NST:1]),
      .v        (vin[c]),
      .gain     (gain),
      .bias     (bias),
      .exponent (exponent),
      .q        (vout[c])
    );
  end

  assign out_data.out_a = vout[0];
  assign out_data.out_b = vout[1];
  assign out_data.out_c = vout[2];

  // checks
  `include "pixel_gamma_contrast_brightness_assert.svh"

  `PGCB_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld[1], "accepted pixel lost")
  `PGCB_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid, "waiting result dropped")
  `PGCB_ASSERT_NEXT(a_gain_write, cfg_we && cfg_index == IDX_GAIN, gain == $past(cfg_data), "gain write missed")

endmodule

`default_nettype wire

@@ tb/sv/pixel_gamma_contrast_brightness_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_gamma_contrast_brightness_checker
// Watches the pixel channels and config writes, computes the corrected pixel
// for each input transfer, and compares the output transfers in order.
// ----------------------------------------------------------------------------
module pixel_gamma_contrast_brightness_checker
  import pgcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  pix_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  pix_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  logic [15:0]        gain_q;
  logic signed [15:0] bias_q;
  logic [15:0]        gamma_q;
  pix_out_t           expected_pixels[$];

  // fixed-point log2 of a nonzero byte, 24 fraction bits
  function automatic longint unsigned byte_log2(input int unsigned v);
    int unsigned     k;
    longint unsigned m;
    longint unsigned fr;
    k = 7;
    fr = 0;
    while (k > 0 && ((v >> k) & 1) == 0) k--;
    m = longint'(v) << (31 - k);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return (longint'(k) << 24) | fr;
  endfunction

  function automatic longint unsigned root64(input longint unsigned a);
    longint unsigned rem, res, bt;
    rem = a;
    res = 0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // (v/255)^g in Q.32 via 2^(-g*(log2 255 - log2 v))
  function automatic longint unsigned pow_q32(input int unsigned v,
                                              input longint unsigned g);
    longint unsigned t, n, f, y, r;
    if (v == 0) return (g == 0) ? (64'd1 << 32) : 64'd0;
    t = ((byte_log2(255) - byte_log2(v)) * g) >> 14;
    n = t >> 24;
    f = t & ((64'd1 << 24) - 1);
    y = 64'd1 << 32;
    r = 64'd1 << 31;
    for (int i = 1; i <= 24; i++) begin
      r = root64(r << 32);
      if ((f >> (24 - i)) & 1) y = (y * r) >> 32;
    end
    if (n >= 63) return 0;
    return y >> n;
  endfunction

  function automatic logic [7:0] correct_channel(input logic [7:0] v);
    longint acc;
    longint unsigned q;
    acc = longint'({48'd0, gain_q}) * longint'(pow_q32(v, gamma_q))
          + (longint'(bias_q) <<< 32);
    acc = acc * 255;
    if (acc <= 0) return 8'd0;
    q = (longint'(acc) + (64'd1 << 45)) >> 46;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pix_out_t e;
    if (rst) begin
      gain_q <= 16'd16384;
      bias_q <= 16'sd0;
      gamma_q <= 16'd16384;
      errors <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          IDX_GAIN:     gain_q <= cfg_data;
          IDX_BIAS:     bias_q <= cfg_data;
          IDX_EXPONENT: gamma_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        e.out_a = correct_channel(in_data.chan_a);
        e.out_b = correct_channel(in_data.chan_b);
        e.out_c = correct_channel(in_data.chan_c);
        expected_pixels.push_back(e);
      end
      // compare each output transfer with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output, actual %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch, expected %h actual %h", $time, e, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/pixel_gamma_contrast_brightness_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_gamma_contrast_brightness_test
// Drives pixels through several gain, bias and gamma settings with random
// bursts and output stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module pixel_gamma_contrast_brightness_test;
  import pgcb_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] IDX_UNUSED = 2'd3;   // no register at this index

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pix_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pix_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = IDX_GAIN;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  always #1 clk = ~clk;

  pixel_gamma_contrast_brightness u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pixel_gamma_contrast_brightness_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver: stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || (($time / 400) % 3 == 0);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("pixel_gamma_contrast_brightness_test: FAIL");
      $finish;
    end
  end

  // one pixel transfer; valid stays up afterwards unless a gap follows
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{chan_a: a, chan_b: b, chan_c: c};
    do @(posedge clk); while (!in_ready);
  endtask

  // write enable stays up between back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] g, input logic [15:0] b,
                         input logic [15:0] e);
    drain();
    write_reg(IDX_GAIN, g);
    write_reg(IDX_BIAS, b);
    write_reg(IDX_EXPONENT, e);
    write_reg(IDX_UNUSED, 16'($urandom));  // no effect
    cfg_we <= 1'b0;
  endtask

  // random pixels in bursts; mostly back to back inside a burst
  task automatic random_pixels(input int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) burst = $urandom_range(1, 40);
      burst--;
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 (burst == 0) ? $urandom_range(0, 12) : 0);
    end
  endtask

  logic [15:0] gains[6] = '{16'd16384, 16'd0, 16'd32768, 16'hFFFF, 16'd8192, 16'd24000};
  logic [15:0] biases[6] = '{16'd0, 16'hC000, 16'h4000, 16'h8000, 16'h7FFF, 16'hF000};
  logic [15:0] gammas[6] = '{16'd16384, 16'd0, 16'd32768, 16'hFFFF, 16'd4096, 16'd1};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero and full channels, each bit alone
    send_pixel(8'd0, 8'd255, 8'd1, 0);
    send_pixel(8'd255, 8'd0, 8'd128, 0);
    for (int i = 0; i < 8; i++) send_pixel(8'd1 << i, ~(8'd1 << i), 8'd254, 0);
    set_all(16'd0, 16'd0, 16'd0);          // 0^0 is one, gain 0 makes it zero
    send_pixel(8'd0, 8'd255, 8'd77, 1);
    set_all(16'd32768, 16'd16384, 16'd32768);  // saturates high
    send_pixel(8'd0, 8'd200, 8'd255, 0);
    set_all(16'd16384, 16'hC000, 16'd16384);   // negative clips to zero
    send_pixel(8'd0, 8'd100, 8'd255, 0);

    // random settings and pixels
    for (int p = 0; p < 6; p++) begin
      set_all(gains[p], biases[p], gammas[p]);
      random_pixels(150);
    end
    for (int p = 0; p < 4; p++) begin
      set_all(16'($urandom), 16'($urandom), 16'($urandom));
      random_pixels(100);
    end
    set_all(16'd16384, 16'd0, 16'd16384);

    // long receiver hold-off while pixels keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_pixels(250);
    join

    drain();
    if (errors == 0) begin
      $display("pixel_gamma_contrast_brightness_test: PASS");
    end else begin
      $display("pixel_gamma_contrast_brightness_test: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/pgcb_pkg.sv
design/pgcb_chan.sv
design/pixel_gamma_contrast_brightness.sv
tb/sv/pixel_gamma_contrast_brightness_checker.sv
tb/sv/pixel_gamma_contrast_brightness_test.sv
